[design/handle_table_allocator_macros.svh]
// Assertion macros used by the handle table allocator engine
`ifndef HANDLE_TABLE_ALLOCATOR_MACROS_SVH
`define HANDLE_TABLE_ALLOCATOR_MACROS_SVH

// Property checked on every clock edge outside reset
`define HTA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, reset included
`define HTA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/hta_pkg.sv]
// Shared types and constants for the handle table allocator
package hta_pkg;

   // Fixed field widths
   localparam int OPCODE_W    = 2;
   localparam int HANDLE_W    = 12;
   localparam int OBJECT_W    = 32;
   localparam int COUNT_W     = 10;
   localparam int CHUNK_W     = 5;
   // Index bits carried by a handle (two application bits below)
   localparam int IDX_SPACE_W = HANDLE_W - 2;
   localparam int HANDLE_SPACE = 1 << IDX_SPACE_W;

   // Defaults
   localparam int MAX_HANDLES_DEF   = 1024;
   localparam int CHUNK_HANDLES_DEF = 64;
   localparam int CHUNK_LIMIT_RESET = 16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CREATE  = 2'd0,
      OP_LOOKUP  = 2'd1,
      OP_DESTROY = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // Entry RAM access from the engine
   typedef struct packed {
      logic                   rd_en;
      logic [IDX_SPACE_W-1:0] rd_addr;
      logic                   wr_en;
      logic [IDX_SPACE_W-1:0] wr_addr;
      logic [OBJECT_W-1:0]    wr_data;
   } mem_req_type;

endpackage

[design/hta_ram.sv]
// Generic single-clock RAM, one write port and one registered read port
module hta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/hta_engine.sv]
// Operation sequencer: entry read, free-list and fresh-index update, write-back
`include "handle_table_allocator_macros.svh"

module hta_engine
   import hta_pkg::*;
#(
   parameter int DEPTH = 1024,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [OPCODE_W-1:0]    req_opcode,
   input  logic [HANDLE_W-1:0]    req_handle_in,
   input  logic [OBJECT_W-1:0]    req_object_value,
   input  logic [CNT_W-1:0]       fresh_bound,
   output mem_req_type            mem_req,
   input  logic [OBJECT_W-1:0]    mem_rd_data,
   output logic                   rsp_strobe,
   output logic [HANDLE_W-1:0]    rsp_handle_out,
   output logic [OBJECT_W-1:0]    rsp_object_out,
   output logic [COUNT_W-1:0]     rsp_live_count
);

   localparam int CMP_W = IDX_SPACE_W + 1;
   // Free link layout: bit 0 set, next index above it, empty flag on top
   localparam int LINK_EMPTY_BIT = IDX_W + 2;

   state_type state_ff, state_in;

   op_type                 op_ff;
   logic [IDX_SPACE_W-1:0] idx_ff;
   logic [OBJECT_W-1:0]    obj_ff;

   logic [IDX_W-1:0] free_head_ff, free_head_in;
   logic             free_empty_ff, free_empty_in;
   logic [CNT_W-1:0] next_fresh_ff, next_fresh_in;
   logic [CNT_W-1:0] in_use_ff, in_use_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [OBJECT_W-1:0] rsp_object_ff, rsp_object_in;

   logic                   accept;
   logic                   obj_ok;
   logic                   fresh_ok;
   logic                   idx_live;
   logic                   got_ok;
   logic [IDX_W-1:0]       got_idx;
   logic [IDX_W-1:0]       link_next;
   logic                   link_empty;
   logic                   wr_en_c;
   logic [IDX_SPACE_W-1:0] wr_addr_c;
   logic [OBJECT_W-1:0]    wr_data_c;

   assign accept = start && (state_ff == ST_IDLE);

   // Decoded view of the entry just read
   assign link_next  = mem_rd_data[IDX_W+1:2];
   assign link_empty = mem_rd_data[LINK_EMPTY_BIT];
   assign obj_ok     = !obj_ff[0] && (|obj_ff[OBJECT_W-1:1]);
   assign fresh_ok   = next_fresh_ff < fresh_bound;
   assign idx_live   = (idx_ff != '0) && (CMP_W'(idx_ff) < CMP_W'(next_fresh_ff))
                       && !mem_rd_data[0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // FSM outputs and RAM request
   always_comb begin
      busy            = (state_ff == ST_EXEC);
      mem_req.rd_en   = accept;
      mem_req.rd_addr = (op_type'(req_opcode) == OP_CREATE) ?
                        IDX_SPACE_W'(free_head_ff) : req_handle_in[HANDLE_W-1:2];
      mem_req.wr_en   = wr_en_c;
      mem_req.wr_addr = wr_addr_c;
      mem_req.wr_data = wr_data_c;
   end

   // Execute: allocation, lookup and free-list push
   always_comb begin
      free_head_in  = free_head_ff;
      free_empty_in = free_empty_ff;
      next_fresh_in = next_fresh_ff;
      in_use_in     = in_use_ff;
      rsp_strobe_in = (state_ff == ST_EXEC);
      rsp_handle_in = '0;
      rsp_object_in = '0;
      got_ok        = 1'b0;
      got_idx       = free_head_ff;
      wr_en_c       = 1'b0;
      wr_addr_c     = idx_ff;
      wr_data_c     = obj_ff;
      if (state_ff == ST_EXEC) begin
         case (op_ff)
            OP_CREATE: begin
               if (obj_ok) begin
                  if (!free_empty_ff) begin
                     // pop the most recently freed handle
                     got_ok        = 1'b1;
                     got_idx       = free_head_ff;
                     free_head_in  = link_next;
                     free_empty_in = link_empty;
                  end else if (fresh_ok) begin
                     got_ok        = 1'b1;
                     got_idx       = next_fresh_ff[IDX_W-1:0];
                     next_fresh_in = next_fresh_ff + 1'b1;
                  end
               end
               if (got_ok) begin
                  wr_en_c       = 1'b1;
                  wr_addr_c     = IDX_SPACE_W'(got_idx);
                  wr_data_c     = obj_ff;
                  in_use_in     = in_use_ff + 1'b1;
                  rsp_handle_in = HANDLE_W'({got_idx, 2'b00});
               end
            end
            OP_LOOKUP: begin
               if (idx_live) begin
                  rsp_object_in = mem_rd_data;
               end
            end
            OP_DESTROY: begin
               if (idx_live) begin
                  // entry becomes a link to the old head
                  rsp_object_in = mem_rd_data;
                  wr_en_c       = 1'b1;
                  wr_addr_c     = idx_ff;
                  wr_data_c     = OBJECT_W'({free_empty_ff, free_head_ff, 2'b01});
                  free_head_in  = idx_ff[IDX_W-1:0];
                  free_empty_in = 1'b0;
                  if (in_use_ff != '0) begin
                     in_use_in = in_use_ff - 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= '0;
         free_empty_ff <= 1'b1;
         next_fresh_ff <= CNT_W'(1);
         in_use_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         free_empty_ff <= free_empty_in;
         next_fresh_ff <= next_fresh_in;
         in_use_ff     <= in_use_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Captured request and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_opcode);
         idx_ff <= req_handle_in[HANDLE_W-1:2];
         obj_ff <= req_object_value;
      end
      if (state_ff == ST_EXEC) begin
         rsp_handle_ff <= rsp_handle_in;
         rsp_object_ff <= rsp_object_in;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_object_out = rsp_object_ff;
   assign rsp_live_count = COUNT_W'(in_use_ff);

   // Checks
   `HTA_ASSERT(a_strobe_after_exec, clock, reset, rsp_strobe_ff |-> $past(state_ff == ST_EXEC), "result strobe without an execute cycle")
   `HTA_ASSERT(a_count_below_fresh, clock, reset, in_use_ff < next_fresh_ff, "live count reached the fresh index")
   `HTA_ASSERT(a_issue_counts, clock, reset, (rsp_strobe_ff && (rsp_handle_ff != '0)) |-> (in_use_ff == CNT_W'($past(in_use_ff) + 1'b1)), "issued handle not counted")
   `HTA_ASSERT(a_destroy_pushes, clock, reset, (rsp_strobe_ff && (rsp_object_ff != '0) && $past(op_ff == OP_DESTROY)) |-> !free_empty_ff, "destroyed handle missing from free list")

endmodule

[design/handle_table_allocator.sv]
// Result path: the request is captured at the transfer edge, the engine enters its execute state,
// and the result strobe and payload are registered from that state.
// Operations do not overlap: each one does an entry RAM read, then write-back
// and free-list head update before the next read; busy is high meanwhile.
// Reset (synchronous): free list empty, next fresh index 1, live count 0, chunk limit 16;
// entry RAM is not cleared and needs no clearing pass. Results cannot be stalled.
module handle_table_allocator
   import hta_pkg::*;
#(
   parameter int MAX_HANDLES   = MAX_HANDLES_DEF,
   parameter int CHUNK_HANDLES = CHUNK_HANDLES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [HANDLE_W-1:0] req_handle_in,
   input  logic [OBJECT_W-1:0] req_object_value,
   output logic                rsp_strobe,
   output logic [HANDLE_W-1:0] rsp_handle_out,
   output logic [OBJECT_W-1:0] rsp_object_out,
   output logic [COUNT_W-1:0]  rsp_live_count,
   input  logic                csr_wr_en,
   input  logic [CHUNK_W-1:0]  csr_wr_data
);

   localparam int DEPTH  = (MAX_HANDLES < HANDLE_SPACE) ? MAX_HANDLES : HANDLE_SPACE;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int PROD_W = CHUNK_W + $clog2(CHUNK_HANDLES + 1);
   localparam int WIDE_W = PROD_W + CNT_W;
   localparam int BOUND_RAW = CHUNK_LIMIT_RESET * CHUNK_HANDLES;
   localparam int BOUND_RST = (BOUND_RAW > DEPTH) ? DEPTH : BOUND_RAW;

   logic [CNT_W-1:0]    fresh_bound_ff, fresh_bound_in;
   logic [WIDE_W-1:0]   bound_prod;
   mem_req_type         mem_req;
   logic [OBJECT_W-1:0] mem_rd_data;

   // Fresh-issue bound: chunk limit times chunk size, capped at the table depth
   assign bound_prod     = WIDE_W'(csr_wr_data) * WIDE_W'(CHUNK_HANDLES);
   assign fresh_bound_in = (bound_prod > WIDE_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(bound_prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_bound_ff <= CNT_W'(BOUND_RST);
      end else if (csr_wr_en) begin
         fresh_bound_ff <= fresh_bound_in;
      end
   end

   // Sequencer
   hta_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_handle_in    (req_handle_in),
      .req_object_value (req_object_value),
      .fresh_bound      (fresh_bound_ff),
      .mem_req          (mem_req),
      .mem_rd_data      (mem_rd_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_handle_out   (rsp_handle_out),
      .rsp_object_out   (rsp_object_out),
      .rsp_live_count   (rsp_live_count)
   );

   // Entry store
   hta_ram #(
      .WIDTH (OBJECT_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr[IDX_W-1:0]),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr[IDX_W-1:0]),
      .rd_data (mem_rd_data)
   );

endmodule

[bench/handle_table_checker.sv]
// Result checker for the handle table allocator: watches both channels and predicts each result
`timescale 1ns / 100ps
module handle_table_checker
   import hta_pkg::*;
#(
   parameter int MAX_HANDLES   = MAX_HANDLES_DEF,
   parameter int CHUNK_HANDLES = CHUNK_HANDLES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [HANDLE_W-1:0] req_handle_in,
   input  logic [OBJECT_W-1:0] req_object_value,
   input  logic                rsp_strobe,
   input  logic [HANDLE_W-1:0] rsp_handle_out,
   input  logic [OBJECT_W-1:0] rsp_object_out,
   input  logic [COUNT_W-1:0]  rsp_live_count,
   input  logic                csr_wr_en,
   input  logic [CHUNK_W-1:0]  csr_wr_data,
   output int unsigned         fail_count,
   output int unsigned         outstanding
);

   // Free-list terminator: one past the last index
   localparam int unsigned NO_INDEX = MAX_HANDLES;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle_word;
      logic [OBJECT_W-1:0] object_word;
      logic [COUNT_W-1:0]  live;
   } outcome_type;

   // Shadow of the table: entries hold an object word or a free link (bit 0 set)
   logic [OBJECT_W-1:0] slot_word [MAX_HANDLES];
   int unsigned         free_top;
   int unsigned         fresh_idx;
   int unsigned         live_handles;
   int unsigned         chunk_lim;
   int unsigned         errs = 0;
   outcome_type         awaited_results [$];

   // An index is live if it was issued and its entry holds an object word
   function automatic bit holds_object(int unsigned idx);
      logic [OBJECT_W-1:0] w;
      if (idx == 0 || idx >= fresh_idx || idx >= MAX_HANDLES)
         return 1'b0;
      w = slot_word[idx];
      return (w != '0) && !w[0];
   endfunction

   // Applies one operation to the shadow table and returns the result it gives
   function automatic outcome_type apply_table_op(op_type op, logic [HANDLE_W-1:0] hin,
                                                  logic [OBJECT_W-1:0] objv);
      outcome_type res;
      int unsigned idx, taken, link_next, bound;
      res   = '0;
      idx   = hin >> 2;
      bound = chunk_lim * CHUNK_HANDLES;
      if (bound > MAX_HANDLES)
         bound = MAX_HANDLES;
      if (bound > HANDLE_SPACE)
         bound = HANDLE_SPACE;
      case (op)
         OP_CREATE: begin
            // Bad object words are refused like a full table
            if (objv != '0 && !objv[0]) begin
               taken = NO_INDEX;
               if (free_top < MAX_HANDLES) begin
                  link_next = slot_word[free_top] >> 2;
                  taken     = free_top;
                  free_top  = (link_next < MAX_HANDLES) ? link_next : NO_INDEX;
               end else if (fresh_idx < bound) begin
                  taken = fresh_idx;
                  fresh_idx++;
               end
               if (taken < MAX_HANDLES) begin
                  slot_word[taken] = objv;
                  live_handles++;
                  res.handle_word = HANDLE_W'(taken << 2);
               end
            end
         end
         OP_LOOKUP: begin
            if (holds_object(idx))
               res.object_word = slot_word[idx];
         end
         OP_DESTROY: begin
            // Hand the object back and push the index onto the free list
            if (holds_object(idx)) begin
               res.object_word = slot_word[idx];
               slot_word[idx]  = OBJECT_W'((free_top << 2) | 1);
               free_top        = idx;
               if (live_handles > 0)
                  live_handles--;
            end
         end
         default: ;
      endcase
      res.live = COUNT_W'(live_handles);
      return res;
   endfunction

   // Predict on each accepted transfer, compare on each result strobe
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         free_top     = NO_INDEX;
         fresh_idx    = 1;
         live_handles = 0;
         chunk_lim    = CHUNK_LIMIT_RESET;
         awaited_results.delete();
      end else begin
         if (csr_wr_en)
            chunk_lim = csr_wr_data;
         if (start && !busy)
            awaited_results.push_back(apply_table_op(op_type'(req_opcode), req_handle_in,
                                                     req_object_value));
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               $error("result strobe with no operation awaiting a result");
               errs++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_handle_out !== want.handle_word) begin
                  $error("handle_out: expected %0h, got %0h", want.handle_word, rsp_handle_out);
                  errs++;
               end
               if (rsp_object_out !== want.object_word) begin
                  $error("object_out: expected %0h, got %0h", want.object_word, rsp_object_out);
                  errs++;
               end
               if (rsp_live_count !== want.live) begin
                  $error("live_count: expected %0d, got %0d", want.live, rsp_live_count);
                  errs++;
               end
            end
         end
      end
      fail_count  <= errs;
      outstanding <= awaited_results.size();
   end

endmodule

[bench/handle_table_allocator_tb.sv]
// Stimulus and verdict for the handle table allocator, with the result checker alongside
`timescale 1ns / 100ps
module handle_table_allocator_tb;
   import hta_pkg::*;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [OPCODE_W-1:0] req_opcode       = '0;
   logic [HANDLE_W-1:0] req_handle_in    = '0;
   logic [OBJECT_W-1:0] req_object_value = '0;
   logic                rsp_strobe;
   logic [HANDLE_W-1:0] rsp_handle_out;
   logic [OBJECT_W-1:0] rsp_object_out;
   logic [COUNT_W-1:0]  rsp_live_count;
   logic                csr_wr_en        = 1'b0;
   logic [CHUNK_W-1:0]  csr_wr_data      = '0;
   int unsigned         fail_count;
   int unsigned         outstanding;

   // Stimulus bookkeeping
   int unsigned idle_pct     = 0;
   int unsigned creates_sent = 0;
   int unsigned op_tally [4] = '{default: 0};
   int unsigned limits_used  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   handle_table_allocator u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_handle_in    (req_handle_in),
      .req_object_value (req_object_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_handle_out   (rsp_handle_out),
      .rsp_object_out   (rsp_object_out),
      .rsp_live_count   (rsp_live_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   handle_table_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_handle_in    (req_handle_in),
      .req_object_value (req_object_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_handle_out   (rsp_handle_out),
      .rsp_object_out   (rsp_object_out),
      .rsp_live_count   (rsp_live_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   // One operation transfer, with an optional random gap in front of it
   task automatic issue_op(input op_type op, input logic [HANDLE_W-1:0] hnd,
                           input logic [OBJECT_W-1:0] objv);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start            <= 1'b1;
      req_opcode       <= op;
      req_handle_in    <= hnd;
      req_object_value <= objv;
      do @(posedge clock); while (busy);
      if (op == OP_CREATE)
         creates_sent++;
      op_tally[op]++;
   endtask

   // Drain, then write the chunk limit while the block is idle
   task automatic set_chunk_limit(input logic [CHUNK_W-1:0] lim);
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lim;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limits_used++;
   endtask

   // Random mix: handles mostly near the issued range, objects mostly well formed
   task automatic random_phase(input logic [CHUNK_W-1:0] lim, input int unsigned gap_pct,
                               input int unsigned count, input int unsigned create_pct);
      op_type              op;
      int unsigned         roll, span, pick;
      logic [HANDLE_W-1:0] hnd;
      logic [OBJECT_W-1:0] objv;
      set_chunk_limit(lim);
      idle_pct = gap_pct;
      for (int unsigned i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < create_pct)
            op = OP_CREATE;
         else if (roll < 95)
            op = $urandom_range(1) ? OP_LOOKUP : OP_DESTROY;
         else
            op = OP_NOP;
         span = creates_sent + 1;
         if (span > HANDLE_SPACE - 1)
            span = HANDLE_SPACE - 1;
         if ($urandom_range(99) < 85)
            hnd = {IDX_SPACE_W'($urandom_range(span)), 2'($urandom_range(3))};
         else
            hnd = HANDLE_W'($urandom);
         objv    = $urandom;
         objv[0] = 1'b0;
         if (objv == '0)
            objv = 32'd2;
         pick = $urandom_range(19);
         if (pick == 0)
            objv = '0;
         else if (pick == 1)
            objv[0] = 1'b1;
         issue_op(op, hnd, objv);
      end
   endtask

   // Run-time ceiling
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: invalid handles, bad objects, reuse from the free list, no-op
      set_chunk_limit(5'd16);
      idle_pct = 0;
      issue_op(OP_LOOKUP,  12'd0,    32'h0000_0000);
      issue_op(OP_DESTROY, 12'd3,    32'h0000_0000);
      issue_op(OP_LOOKUP,  12'd4092, 32'h0000_0000);
      issue_op(OP_CREATE,  12'd0,    32'h0000_0000);
      issue_op(OP_CREATE,  12'd0,    32'hFFFF_FFFF);
      issue_op(OP_CREATE,  12'd0,    32'hFFFF_FFFE);
      issue_op(OP_CREATE,  12'hFFF,  32'h0000_0002);
      issue_op(OP_CREATE,  12'd0,    32'h5555_AAAA);
      issue_op(OP_LOOKUP,  12'd7,    32'hFFFF_FFFF);
      issue_op(OP_LOOKUP,  12'd8,    32'h0000_0000);
      issue_op(OP_DESTROY, 12'd4,    32'h0000_0000);
      issue_op(OP_LOOKUP,  12'd4,    32'h0000_0000);
      issue_op(OP_DESTROY, 12'd6,    32'h0000_0000);
      issue_op(OP_CREATE,  12'd0,    32'h1234_5678);
      issue_op(OP_NOP,     12'hFFF,  32'hFFFF_FFFF);
      issue_op(OP_DESTROY, 12'd8,    32'h0000_0000);
      issue_op(OP_DESTROY, 12'd12,   32'h0000_0000);
      issue_op(OP_CREATE,  12'd0,    32'hAAAA_0000);
      issue_op(OP_CREATE,  12'd0,    32'h0000_0010);
      issue_op(OP_CREATE,  12'd0,    32'h8000_0000);
      issue_op(OP_LOOKUP,  12'd16,   32'h0000_0000);
      issue_op(OP_DESTROY, 12'd4092, 32'h0000_0000);

      // Random: zero limit, tiny table filling up, full range, then limit lowered
      random_phase(5'd0,  77, 200, 40);
      random_phase(5'd1,  30, 400, 60);
      random_phase(5'd31,  0, 500, 80);
      random_phase(5'd31, 77, 500, 75);
      random_phase(5'd16, 30, 300, 50);
      random_phase(5'd2,   0, 300, 55);

      // Drain and give the verdict
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("Ran %0d creates, %0d lookups, %0d destroys and %0d no-ops",
               op_tally[OP_CREATE], op_tally[OP_LOOKUP], op_tally[OP_DESTROY],
               op_tally[OP_NOP]);
      $display("over %0d chunk-limit writes (0 to 31), with sender gaps of 0, 30 and 77 %%",
               limits_used);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/hta_pkg.sv
design/hta_ram.sv
design/hta_engine.sv
design/handle_table_allocator.sv
bench/handle_table_checker.sv
bench/handle_table_allocator_tb.sv
